[src/ahs_pkg.sv]
// shared types and constants for the address hash set
`timescale 1ns / 1ps

package ahs_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W    = 64;
  localparam int BUCKET_W = 8;
  localparam int ENTRY_W  = 9;
  localparam int MAXE_W   = 9;
  localparam int CMP_W    = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
  localparam int HASH_W   = 32;
  localparam int BYTES    = KEY_W / 8;
  localparam int BYTE_W   = $clog2(BYTES);

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [MAXE_W-1:0] MAXE_RESET = 9'd192;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4,
    ST_NULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_USED  = 2'd1,
    TAG_GONE  = 2'd2
  } tag_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic rd_en;
    logic check;
    logic finish;
  } ahs_cmd_t;

  typedef struct packed {
    logic key_zero;
    logic hash_last;
    logic probe_stop;
  } ahs_sts_t;

endpackage

[src/ahs_ctrl.sv]
// request sequencer: hashing, probe loop and result strobe
`timescale 1ns / 1ps

module ahs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ahs_pkg::ahs_sts_t sts,
  output ahs_pkg::ahs_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import ahs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_HASH   = 5'b00010,
    S_READ   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.key_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.hash_step = 1'b1;
          if (sts.hash_last) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.probe_stop ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FINISH);
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[src/ahs_dp.sv]
// datapath: fnv-1a hash, key and tag stores, probe registers, result registers
`timescale 1ns / 1ps

module ahs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ahs_pkg::ahs_cmd_t             cmd,
  output ahs_pkg::ahs_sts_t             sts,
  input  logic                          in_command,
  input  logic [ahs_pkg::KEY_W-1:0]     in_key,
  input  logic                          cfg_we,
  input  logic [ahs_pkg::MAXE_W-1:0]    cfg_wdata,
  output logic [2:0]                    out_status,
  output logic [ahs_pkg::BUCKET_W-1:0]  out_bucket,
  output logic [ahs_pkg::ENTRY_W-1:0]   out_entry_total
);
  import ahs_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_VISIT = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [CMP_W-1:0]  TABLE_CAP  = CMP_W'(TABLE_ENTRIES);

  // key and tag stores
  logic [KEY_W-1:0]         key_mem [TABLE_ENTRIES];
  tag_t                     tag_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;

  command_t             cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [HASH_W-1:0]    hash_r;
  logic [BYTE_W-1:0]    byte_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [SLOT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]    last_r;
  logic [SLOT_W-1:0]    hole_r;
  logic                 hole_vld_r;
  logic                 found_r;
  logic [CNT_W-1:0]     used_r;
  logic [MAXE_W-1:0]    max_r;
  logic [KEY_W-1:0]     rd_key_r;
  tag_t                 rd_tag_r;
  logic                 rd_vld_r;
  status_t              out_status_r;
  logic [BUCKET_W-1:0]  out_bucket_r;
  logic [ENTRY_W-1:0]   out_total_r;

  logic [7:0]           key_byte;
  logic [HASH_W-1:0]    hash_mix;
  logic [HASH_W-1:0]    hash_nxt;
  tag_t                 tag_now;
  logic                 is_empty;
  logic                 is_gone;
  logic                 is_hit;
  logic [CMP_W-1:0]     limit;
  logic                 at_limit;
  status_t              res_status;
  logic [SLOT_W-1:0]    res_bucket;
  logic [CNT_W-1:0]     used_nxt;
  logic                 wr_key_en;
  logic                 wr_tag_en;
  logic [SLOT_W-1:0]    wr_addr;
  tag_t                 wr_tag;

  // one byte per cycle, low byte first
  assign key_byte = key_r[8*byte_r +: 8];
  assign hash_mix = hash_r ^ HASH_W'(key_byte);
  assign hash_nxt = hash_mix * FNV_PRIME;

  assign tag_now  = rd_vld_r ? rd_tag_r : TAG_EMPTY;
  assign is_empty = (tag_now == TAG_EMPTY);
  assign is_gone  = (tag_now == TAG_GONE);
  assign is_hit   = (tag_now == TAG_USED) && (rd_key_r == key_r);

  assign sts.key_zero   = (key_r == '0);
  assign sts.hash_last  = (byte_r == BYTE_W'(BYTES - 1));
  assign sts.probe_stop = is_empty || is_hit || (cnt_r == LAST_VISIT);

  assign limit    = (CMP_W'(max_r) > TABLE_CAP) ? TABLE_CAP : CMP_W'(max_r);
  assign at_limit = (CMP_W'(used_r) >= limit);

  // outcome of a request
  always_comb begin
    res_status = ST_NULL;
    res_bucket = '0;
    used_nxt   = used_r;
    wr_key_en  = 1'b0;
    wr_tag_en  = 1'b0;
    wr_addr    = last_r;
    wr_tag     = TAG_USED;
    if (key_r == '0) begin
      res_status = ST_NULL;
    end else if (found_r) begin
      res_bucket = last_r;
      if (cmd_r == CMD_INSERT) begin
        res_status = ST_PRESENT;
      end else begin
        res_status = ST_REMOVED;
        wr_tag_en  = 1'b1;
        wr_tag     = TAG_GONE;
        if (used_r != '0) begin
          used_nxt = used_r - CNT_W'(1);
        end
      end
    end else if (cmd_r == CMD_DELETE) begin
      res_status = ST_MISSING;
      res_bucket = last_r;
    end else if (at_limit || !hole_vld_r) begin
      res_status = ST_FULL;
      res_bucket = last_r;
    end else begin
      res_status = ST_INSERTED;
      res_bucket = hole_r;
      wr_addr    = hole_r;
      wr_key_en  = 1'b1;
      wr_tag_en  = 1'b1;
      used_nxt   = used_r + CNT_W'(1);
    end
  end

  // request, hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= command_t'(in_command);
      key_r      <= in_key;
      hash_r     <= FNV_BASIS;
      byte_r     <= '0;
      found_r    <= 1'b0;
      hole_vld_r <= 1'b0;
    end
    if (cmd.hash_step) begin
      hash_r <= hash_nxt;
      byte_r <= byte_r + BYTE_W'(1);
      if (sts.hash_last) begin
        slot_r <= hash_nxt[SLOT_W-1:0];
        cnt_r  <= '0;
      end
    end
    if (cmd.check) begin
      last_r <= slot_r;
      slot_r <= slot_r + SLOT_W'(1);
      cnt_r  <= cnt_r + SLOT_W'(1);
      if (is_hit) begin
        found_r <= 1'b1;
      end
      if (!hole_vld_r && (is_empty || is_gone)) begin
        hole_r     <= slot_r;
        hole_vld_r <= 1'b1;
      end
    end
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_bucket_r <= BUCKET_W'(res_bucket);
      out_total_r  <= ENTRY_W'(used_nxt);
    end
  end

  // store ports
  always_ff @(posedge clk) begin
    if (cmd.finish && wr_key_en) begin
      key_mem[wr_addr] <= key_r;
    end
    if (cmd.finish && wr_tag_en) begin
      tag_mem[wr_addr] <= wr_tag;
    end
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[slot_r];
      rd_tag_r <= tag_mem[slot_r];
      rd_vld_r <= vld_r[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      used_r <= '0;
      max_r  <= MAXE_RESET;
    end else begin
      if (cmd.finish && wr_tag_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.finish) begin
        used_r <= used_nxt;
      end
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  assign out_status      = out_status_r;
  assign out_bucket      = out_bucket_r;
  assign out_entry_total = out_total_r;

endmodule

[src/address_hash_set_unit.sv]
// top level of the address hash set
`timescale 1ns / 1ps

// Set of 64-bit addresses in a 256-slot open-addressing table. A request is
// taken when start is high and busy is low; it hashes the key with FNV-1a, one
// byte per cycle through the 32-bit multiplier, then probes linearly, visiting
// each slot with a registered read of the key and tag stores, then a compare.
// A null key skips hashing and probing. A new request is taken only once busy
// is low again. The result appears for one cycle with out_valid, in the first
// cycle with busy low, and must be captured then because the block cannot be
// held off. The fill limit on cfg_wdata may be written whenever no request is
// in flight.
module address_hash_set_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [ahs_pkg::KEY_W-1:0]     in_key,
  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [ahs_pkg::BUCKET_W-1:0]  out_bucket,
  output logic [ahs_pkg::ENTRY_W-1:0]   out_entry_total,
  input  logic                          cfg_we,
  input  logic [ahs_pkg::MAXE_W-1:0]    cfg_wdata
);
  import ahs_pkg::*;

  ahs_cmd_t cmd;
  ahs_sts_t sts;

  ahs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ahs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_command),
    .in_key          (in_key),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_status      (out_status),
    .out_bucket      (out_bucket),
    .out_entry_total (out_entry_total)
  );

endmodule

[src/ahs_checker.sv]
// port-level checks for the address hash set, bound to the top level
`timescale 1ns / 1ps

module ahs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [2:0]                    out_status,
  input logic [ahs_pkg::BUCKET_W-1:0]  out_bucket,
  input logic [ahs_pkg::ENTRY_W-1:0]   out_entry_total
);
  import ahs_pkg::*;

  // an accepted request keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  // results are never back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on two cycles in a row");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= 3'(ST_NULL)))
    else $error("undefined status code");

  a_null_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(ST_NULL)) |-> (out_bucket == '0))
    else $error("null key result with nonzero bucket");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(ST_INSERTED)) |-> (out_entry_total != '0))
    else $error("insert reported with empty table");

endmodule

bind address_hash_set_unit ahs_checker u_ahs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_bucket      (out_bucket),
  .out_entry_total (out_entry_total)
);
